>>> hdl/jubr_pkg.sv
// Package for the JPEG unstuffing bit reader: field widths, codes, shared types.
// No dependencies; compiled first.
package jubr_pkg;

   // Payload widths
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 6;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int RECENT_W = 16;
   localparam int POS_W    = 4;
   localparam int CHUNK_W  = 4;

   // Sizing defaults and limits
   localparam int DEFAULT_FIFO_DEPTH = 8;
   localparam int MAX_READ_BITS      = 32;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   // Marker bytes
   localparam logic [RECENT_W-1:0] EOI_MARKER = 16'hFFD9;
   localparam logic [BYTE_W-1:0]   STUFF_LEAD = 8'hFF;
   localparam logic [BYTE_W-1:0]   STUFF_ZERO = 8'h00;

   // Bit position meaning "current byte used up, fetch needed"
   localparam logic [POS_W-1:0] POS_EMPTY = 4'd8;

   // Operands of the shared bit extract unit
   typedef struct packed {
      logic [BYTE_W-1:0]   cur;
      logic [POS_W-1:0]    pos;
      logic [COUNT_W-1:0]  rem;
      logic [VALUE_W-1:0]  value;
      logic [RECENT_W-1:0] recent;
   } sh_in_type;

   // Results of the shared bit extract unit
   typedef struct packed {
      logic [CHUNK_W-1:0]  taken;
      logic [VALUE_W-1:0]  value;
      logic [RECENT_W-1:0] recent;
   } sh_out_type;

endpackage

>>> hdl/jubr_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on jubr_pkg.
interface jubr_req_if;
   import jubr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [BYTE_W-1:0]    byte_value;
   logic [COUNT_W-1:0]   bit_count;
   logic                 drop_stuffing;

   modport source (output valid, operation, byte_value, bit_count, drop_stuffing,
                   input ready);
   modport sink   (input valid, operation, byte_value, bit_count, drop_stuffing,
                   output ready);
endinterface

interface jubr_rsp_if;
   import jubr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   bits_value;
   logic [COUNT_W-1:0]   bits_taken;
   logic                 end_of_image;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, bits_value, bits_taken, end_of_image, status,
                   input ready);
   modport sink   (input valid, bits_value, bits_taken, end_of_image, status,
                   output ready);
endinterface

>>> hdl/jubr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module jubr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/jubr_shift_unit.sv
// Shared bit extract unit: takes as many bits as fit from the current byte
// and shifts them into the read value and the recent-bits window. Uses jubr_pkg.
module jubr_shift_unit (
   input  jubr_pkg::sh_in_type  sh_in,
   output jubr_pkg::sh_out_type sh_out
);
   import jubr_pkg::*;

   logic [POS_W-1:0]   avail;
   logic [CHUNK_W-1:0] take;
   logic [BYTE_W-1:0]  aligned;
   logic [BYTE_W-1:0]  chunk;

   // Bits left in the byte versus bits still wanted
   assign avail = POS_EMPTY - sh_in.pos;
   assign take  = (sh_in.rem < COUNT_W'(avail)) ? CHUNK_W'(sh_in.rem) : CHUNK_W'(avail);

   // MSB-first extraction: drop used bits, then right-align the chunk
   assign aligned = sh_in.cur << sh_in.pos[2:0];
   assign chunk   = aligned >> (CHUNK_W'(BYTE_W) - take);

   always_comb begin
      sh_out.taken  = take;
      sh_out.value  = (sh_in.value << take) | VALUE_W'(chunk);
      sh_out.recent = (sh_in.recent << take) | RECENT_W'(chunk);
   end

endmodule

>>> hdl/jpeg_unstuffing_bit_reader_unit.sv
// Top level of the JPEG unstuffing bit reader: sequencer, byte FIFO, result register.
// Depends on jubr_pkg, jubr_if, jubr_ram and jubr_shift_unit.
//
// Usage:
//   req_bus carries one beat per operation. A push (operation 0) appends
//   byte_value to the byte FIFO; a read (operation 1) takes bit_count bits
//   (saturated at 32), MSB first, dropping a 0x00 that follows 0xFF when
//   drop_stuffing is set. Each request gives exactly one beat on rsp_bus
//   with bits_value, bits_taken, end_of_image and status.
//   A push passes from accept through the finish state to the response
//   beat. A read steps once per chunk of bits taken from one byte, and
//   fetches each byte from the FIFO through a fetch and a data state (a
//   dropped stuff byte costs one more fetch). The pace is set by the bit
//   extract unit, which handles at most one byte per cycle, and by the
//   registered read of the FIFO memory.
//   One request is in work at a time; req_bus.ready is high only while idle.
//   A failed read (too few bytes) changes no state and reports underflow.
//   Reset empties the FIFO, clears the recent-bits window and marks the
//   current byte as used up. No clearing pass is needed.
//   When the receiver stalls, the finished response waits in the output
//   register; the next request may be accepted meanwhile and its own result
//   is held until the register frees.
module jpeg_unstuffing_bit_reader_unit #(
   parameter int FIFO_DEPTH = jubr_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   jubr_req_if.sink   req_bus,
   jubr_rsp_if.source rsp_bus
);
   import jubr_pkg::*;

   localparam int AW = $clog2(FIFO_DEPTH);
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = FW + 1;
   localparam logic [FW-1:0] DEPTH_F  = FW'(FIFO_DEPTH);
   localparam logic [SW-1:0] DEPTH_S  = SW'(FIFO_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_STEP   = 3'd1;
   localparam logic [2:0] S_FETCH  = 3'd2;
   localparam logic [2:0] S_DATA   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + AW'(1);
   endfunction

   logic [2:0]          state_ff, state_in;

   // Committed reader state
   logic [AW-1:0]       head_ff, head_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [BYTE_W-1:0]   cur_ff, cur_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [RECENT_W-1:0] recent_ff, recent_in;

   // Working copy for a read in progress
   logic [AW-1:0]       w_head_ff, w_head_in;
   logic [FW-1:0]       w_fill_ff, w_fill_in;
   logic [BYTE_W-1:0]   w_cur_ff, w_cur_in;
   logic [POS_W-1:0]    w_pos_ff, w_pos_in;
   logic [RECENT_W-1:0] w_recent_ff, w_recent_in;
   logic [VALUE_W-1:0]  w_value_ff, w_value_in;
   logic [COUNT_W-1:0]  w_rem_ff, w_rem_in;
   logic                skip_ff, skip_in;
   logic                drop_ff, drop_in;

   // Pending result
   logic [VALUE_W-1:0]  res_value_ff, res_value_in;
   logic [COUNT_W-1:0]  res_taken_ff, res_taken_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_taken_ff;
   logic                rsp_eoi_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_load;

   // FIFO memory and shared unit hookups
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [AW-1:0]       tail;
   logic [SW-1:0]       tail_sum;
   logic [BYTE_W-1:0]   ram_rd_data;
   logic [COUNT_W-1:0]  count_sat;
   sh_in_type           sh_in;
   sh_out_type          sh_out;

   // Tail index: head plus fill, wrapped once
   assign tail_sum = SW'(head_ff) + SW'(fill_ff);
   assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

   assign count_sat = (req_bus.bit_count > COUNT_W'(MAX_READ_BITS)) ?
                      COUNT_W'(MAX_READ_BITS) : req_bus.bit_count;

   jubr_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(FIFO_DEPTH)
   ) u_fifo_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(tail),
      .wr_data(req_bus.byte_value),
      .rd_en  (ram_rd_en),
      .rd_addr(w_head_ff),
      .rd_data(ram_rd_data)
   );

   assign sh_in = '{cur: w_cur_ff, pos: w_pos_ff, rem: w_rem_ff,
                    value: w_value_ff, recent: w_recent_ff};

   jubr_shift_unit u_shift (
      .sh_in (sh_in),
      .sh_out(sh_out)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      recent_in     = recent_ff;
      w_head_in     = w_head_ff;
      w_fill_in     = w_fill_ff;
      w_cur_in      = w_cur_ff;
      w_pos_in      = w_pos_ff;
      w_recent_in   = w_recent_ff;
      w_value_in    = w_value_ff;
      w_rem_in      = w_rem_ff;
      skip_in       = skip_ff;
      drop_in       = drop_ff;
      res_value_in  = res_value_ff;
      res_taken_in  = res_taken_ff;
      res_status_in = res_status_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rsp_load      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.operation == OP_PUSH) begin
                  res_value_in = '0;
                  res_taken_in = '0;
                  if (fill_ff == DEPTH_F) begin
                     res_status_in = ST_FULL;
                  end else begin
                     ram_wr_en     = 1'b1;
                     fill_in       = fill_ff + FW'(1);
                     res_status_in = ST_OK;
                  end
                  state_in = S_FINISH;
               end else begin
                  w_head_in    = head_ff;
                  w_fill_in    = fill_ff;
                  w_cur_in     = cur_ff;
                  w_pos_in     = pos_ff;
                  w_recent_in  = recent_ff;
                  w_value_in   = '0;
                  w_rem_in     = count_sat;
                  res_taken_in = count_sat;
                  skip_in      = 1'b0;
                  drop_in      = req_bus.drop_stuffing;
                  state_in     = S_STEP;
               end
            end
         end
         S_STEP: begin
            if (w_rem_ff == '0) begin
               // all bits in hand: commit the working copy
               head_in       = w_head_ff;
               fill_in       = w_fill_ff;
               cur_in        = w_cur_ff;
               pos_in        = w_pos_ff;
               recent_in     = w_recent_ff;
               res_value_in  = w_value_ff;
               res_status_in = ST_OK;
               state_in      = S_FINISH;
            end else if (w_pos_ff == POS_EMPTY) begin
               if (w_fill_ff == '0) begin
                  res_value_in  = '0;
                  res_taken_in  = '0;
                  res_status_in = ST_UNDERFLOW;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               w_value_in  = sh_out.value;
               w_recent_in = sh_out.recent;
               w_pos_in    = w_pos_ff + POS_W'(sh_out.taken);
               w_rem_in    = w_rem_ff - COUNT_W'(sh_out.taken);
            end
         end
         S_FETCH: begin
            ram_rd_en = 1'b1;
            w_head_in = next_index(w_head_ff);
            w_fill_in = w_fill_ff - FW'(1);
            state_in  = S_DATA;
         end
         S_DATA: begin
            // stuffed zero after 0xFF: throw it away, fetch once more untested
            if (drop_ff && !skip_ff && w_recent_ff[BYTE_W-1:0] == STUFF_LEAD &&
                ram_rd_data == STUFF_ZERO) begin
               skip_in = 1'b1;
               if (w_fill_ff == '0) begin
                  res_value_in  = '0;
                  res_taken_in  = '0;
                  res_status_in = ST_UNDERFLOW;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_FETCH;
               end
            end else begin
               w_cur_in = ram_rd_data;
               w_pos_in = '0;
               skip_in  = 1'b0;
               state_in = S_STEP;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and reader state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         cur_ff       <= '0;
         pos_ff       <= POS_EMPTY;
         recent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cur_ff       <= cur_in;
         pos_ff       <= pos_in;
         recent_ff    <= recent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working copy and payload
   always_ff @(posedge clock) begin
      w_head_ff     <= w_head_in;
      w_fill_ff     <= w_fill_in;
      w_cur_ff      <= w_cur_in;
      w_pos_ff      <= w_pos_in;
      w_recent_ff   <= w_recent_in;
      w_value_ff    <= w_value_in;
      w_rem_ff      <= w_rem_in;
      skip_ff       <= skip_in;
      drop_ff       <= drop_in;
      res_value_ff  <= res_value_in;
      res_taken_ff  <= res_taken_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_taken_ff  <= res_taken_ff;
         rsp_eoi_ff    <= (recent_ff == EOI_MARKER);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.bits_value   = rsp_value_ff;
   assign rsp_bus.bits_taken   = rsp_taken_ff;
   assign rsp_bus.end_of_image = rsp_eoi_ff;
   assign rsp_bus.status       = rsp_status_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_F)
      else $error("fifo fill above depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_EMPTY)
      else $error("bit position out of range");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_load && res_status_ff == ST_FULL |-> fill_ff == DEPTH_F)
      else $error("full status while fifo has room");

   a_fail_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_value_ff == '0 && rsp_taken_ff == '0)
      else $error("failed beat carries data");

   a_value_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_taken_ff < COUNT_W'(VALUE_W) |->
         (rsp_value_ff >> rsp_taken_ff) == '0)
      else $error("bits_value wider than bits_taken");

endmodule
